// File: rtl/erc_pkg.sv
// shared constants, types and handshake structs of the event rate classifier
`default_nettype none

package erc_pkg;

	// history ring and interval sizing
	localparam int HIST_DEPTH    = 32;
	localparam int INTERVAL_BITS = 16;
	localparam int IDX_W         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CNT_W         = $clog2(HIST_DEPTH + 1);

	// fixed field widths
	localparam int LIM_W  = 16;
	localparam int WIN_W  = 6;
	localparam int AVG_W  = 16;
	localparam int STAT_W = 32;
	localparam int TS_W   = 32;

	// weighted average datapath
	localparam int X_W   = INTERVAL_BITS + IDX_W;
	localparam int REC_K = X_W;
	localparam int REC_W = REC_K + 1;
	localparam int SUM_W = INTERVAL_BITS + 1 + CNT_W;
	localparam int DVD_W = SUM_W + 1;
	localparam int DVS_W = $clog2(3 * HIST_DEPTH);

	localparam logic [AVG_W-1:0] DEFAULT_AVG = AVG_W'(150);

	// speed class codes
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_NORMAL = 2'd0;
	localparam cls_t CLS_FAST   = 2'd1;
	localparam cls_t CLS_SLOW   = 2'd2;
	localparam cls_t CLS_PAUSED = 2'd3;

	// request type codes
	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// average unit request and response
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] n;
		logic [IDX_W-1:0] oldest;
	} avg_req_t;

	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] avg;
	} avg_rsp_t;

	// serial divider request and response
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/erc_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module erc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/erc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module erc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire erc_pkg::div_req_t div_req,
	output erc_pkg::div_rsp_t      div_rsp
);

	localparam int DC_W = $clog2(erc_pkg::DVD_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [DC_W-1:0]             cnt_q;
	logic [erc_pkg::DVD_W-1:0]   quo_q;
	logic [erc_pkg::DVS_W-1:0]   rem_q;
	logic [erc_pkg::DVS_W-1:0]   dvs_q;

	logic [erc_pkg::DVS_W:0]     rem_sh;
	logic [erc_pkg::DVS_W:0]     rem_sub;
	logic                        ge;

	// one shift and trial subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[erc_pkg::DVD_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DC_W'(erc_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			quo_q <= div_req.dividend;
			rem_q <= '0;
			dvs_q <= div_req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[erc_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[erc_pkg::DVS_W-1:0] : rem_sh[erc_pkg::DVS_W-1:0];
		end
	end

	assign div_rsp.done     = done_q;
	assign div_rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/erc_avg.sv
// weighted average unit: walks the interval ring and divides the weighted sum
`default_nettype none

module erc_avg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire erc_pkg::avg_req_t                    avg_req,
	output erc_pkg::avg_rsp_t                         avg_rsp,
	output logic                                      rd_en,
	output logic [erc_pkg::IDX_W-1:0]                 rd_addr,
	input  wire logic [erc_pkg::INTERVAL_BITS-1:0]    rd_data
);

	localparam int P_W  = erc_pkg::X_W + erc_pkg::REC_W;
	localparam int QN_W = erc_pkg::X_W + erc_pkg::CNT_W;

	// reciprocal table, floor(2^k / n)
	logic [erc_pkg::REC_W-1:0] recip [erc_pkg::HIST_DEPTH+1];
	assign recip[0] = '0;
	for (genvar g = 1; g <= erc_pkg::HIST_DEPTH; g++) begin : g_rec
		localparam logic [erc_pkg::REC_W-1:0] RecVal =
			erc_pkg::REC_W'((64'd1 << erc_pkg::REC_K) / g);
		assign recip[g] = RecVal;
	end

	// walk control
	logic                       issue_q;
	logic                       dflt_q;
	logic                       div_go_q;
	logic [erc_pkg::CNT_W-1:0]  n_q;
	logic [erc_pkg::CNT_W-1:0]  i_q;
	logic [erc_pkg::IDX_W-1:0]  addr_q;
	logic                       last_issue;

	// pipeline
	logic                               v_s1, v_s2, v_s3, v_s4;
	logic                               last_s1, last_s2, last_s3, last_s4;
	logic [erc_pkg::IDX_W-1:0]          i_s1;
	logic [erc_pkg::INTERVAL_BITS-1:0]  iv_s2, iv_s3, iv_s4;
	logic [erc_pkg::X_W-1:0]            x_s2, x_s3, x_s4;
	logic [P_W-1:0]                     p_s3;
	logic [erc_pkg::X_W-1:0]            q_s4;
	logic [QN_W-1:0]                    qn_s4;
	logic [erc_pkg::SUM_W-1:0]          sum_q;

	logic [erc_pkg::X_W-1:0]            q_est;
	logic [QN_W-1:0]                    rem;
	logic                               q_fix;
	logic [erc_pkg::SUM_W-1:0]          term;

	erc_pkg::div_req_t div_req;
	erc_pkg::div_rsp_t div_rsp;

	assign last_issue = (i_q == n_q - 1'b1);
	assign rd_en      = issue_q;
	assign rd_addr    = addr_q;

	// address walk from the oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			dflt_q   <= 1'b0;
			div_go_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			dflt_q   <= 1'b0;
			div_go_q <= v_s4 && last_s4;
			if (avg_req.start) begin
				if (avg_req.n == '0) begin
					dflt_q <= 1'b1;
				end else begin
					issue_q <= 1'b1;
				end
			end else if (issue_q && last_issue) begin
				issue_q <= 1'b0;
			end
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// walk counters
	always_ff @(posedge clk) begin
		if (avg_req.start) begin
			n_q    <= avg_req.n;
			i_q    <= '0;
			addr_q <= avg_req.oldest;
		end else if (issue_q) begin
			i_q    <= i_q + 1'b1;
			addr_q <= (addr_q == erc_pkg::IDX_W'(erc_pkg::HIST_DEPTH - 1)) ? '0 : addr_q + 1'b1;
		end
	end

	// quotient estimate and one-step correction
	always_comb begin
		q_est = p_s3[erc_pkg::REC_K +: erc_pkg::X_W];
		rem   = QN_W'(x_s4) - qn_s4;
		q_fix = rem >= QN_W'(n_q);
		term  = erc_pkg::SUM_W'(iv_s4) + erc_pkg::SUM_W'(q_s4) + erc_pkg::SUM_W'(q_fix);
	end

	// per entry: iv + floor(iv * i / n)
	always_ff @(posedge clk) begin
		last_s1 <= last_issue;
		i_s1    <= i_q[erc_pkg::IDX_W-1:0];
		last_s2 <= last_s1;
		iv_s2   <= rd_data;
		x_s2    <= erc_pkg::X_W'(rd_data) * erc_pkg::X_W'(i_s1);
		last_s3 <= last_s2;
		iv_s3   <= iv_s2;
		x_s3    <= x_s2;
		p_s3    <= P_W'(x_s2) * P_W'(recip[n_q]);
		last_s4 <= last_s3;
		iv_s4   <= iv_s3;
		x_s4    <= x_s3;
		q_s4    <= q_est;
		qn_s4   <= QN_W'(q_est) * QN_W'(n_q);
		if (avg_req.start) begin
			sum_q <= '0;
		end else if (v_s4) begin
			sum_q <= sum_q + term;
		end
	end

	// final divide: 2 * sum / (3n - 1)
	always_comb begin
		div_req.start    = div_go_q;
		div_req.dividend = {sum_q, 1'b0};
		div_req.divisor  = (erc_pkg::DVS_W'(n_q) << 1) + erc_pkg::DVS_W'(n_q) - 1'b1;
	end

	erc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// default average when n is zero, else the saturated quotient
	always_comb begin
		avg_rsp.done = dflt_q || div_rsp.done;
		if (dflt_q) begin
			avg_rsp.avg = erc_pkg::DEFAULT_AVG;
		end else if (div_rsp.quotient > erc_pkg::DVD_W'({erc_pkg::AVG_W{1'b1}})) begin
			avg_rsp.avg = '1;
		end else begin
			avg_rsp.avg = div_rsp.quotient[erc_pkg::AVG_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/event_rate_classifier.sv
// top level of the event rate classifier
`default_nettype none

// Classifies typing speed from timestamped events and answers status queries.
// Every request gives one result word. A query's word is loaded from the
// current state, the first event's word once its stamp is kept, and an
// event with a window length of zero still writes its interval but reports
// the default average. Any other event writes its interval into the history ring
// and then walks the n kept intervals one per cycle through the ring's read
// port and a short multiply pipeline, followed by the serial divider that
// makes one quotient bit per cycle. One request is worked on at a time; the
// next is taken as soon as the current result sits in the output register.
module event_rate_classifier (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [erc_pkg::LIM_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        req_type,
	input  wire logic [erc_pkg::TS_W-1:0]    now_ms,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       speed_class,
	output logic [erc_pkg::AVG_W-1:0]        avg_interval_ms,
	output logic [erc_pkg::STAT_W-1:0]       total_events,
	output logic [erc_pkg::STAT_W-1:0]       fast_count,
	output logic [erc_pkg::STAT_W-1:0]       normal_count,
	output logic [erc_pkg::STAT_W-1:0]       slow_count,
	output logic [erc_pkg::STAT_W-1:0]       pause_count
);

	// register indexes
	localparam logic [1:0] CFG_FAST  = 2'd0;
	localparam logic [1:0] CFG_SLOW  = 2'd1;
	localparam logic [1:0] CFG_PAUSE = 2'd2;
	localparam logic [1:0] CFG_WIN   = 2'd3;

	// counter slots
	localparam int BIN_TOTAL  = 0;
	localparam int BIN_FAST   = 1;
	localparam int BIN_NORMAL = 2;
	localparam int BIN_SLOW   = 3;
	localparam int BIN_PAUSE  = 4;
	localparam int NUM_BINS   = 5;

	// states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_IVAL  = 3'd1;
	localparam logic [2:0] ST_BIN   = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_CLASS = 3'd5;

	localparam int IB    = erc_pkg::INTERVAL_BITS;
	localparam int CNT_W = erc_pkg::CNT_W;
	localparam int CMP_W = (IB > erc_pkg::LIM_W) ? IB : erc_pkg::LIM_W;
	localparam int WC_W  = (CNT_W > erc_pkg::WIN_W) ? CNT_W : erc_pkg::WIN_W;
	localparam int OW    = CNT_W + 1;
	localparam logic [erc_pkg::TS_W-1:0] IV_MAX =
		erc_pkg::TS_W'((64'd1 << IB) - 64'd1);

	function automatic logic [erc_pkg::STAT_W-1:0] sat_inc(
		input logic [erc_pkg::STAT_W-1:0] v
	);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	logic [erc_pkg::LIM_W-1:0]  fast_lim_q, slow_lim_q, pause_lim_q;
	logic [erc_pkg::WIN_W-1:0]  win_len_q;

	logic [2:0]                       state_q;
	logic [erc_pkg::TS_W-1:0]         now_q;
	logic                             seen_q;
	logic [erc_pkg::TS_W-1:0]         last_q;
	logic [IB-1:0]                    iv_q;
	logic [erc_pkg::IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]                 count_q;
	logic [erc_pkg::STAT_W-1:0]       bin_q [NUM_BINS];
	logic [erc_pkg::AVG_W-1:0]        avg_q;

	logic                             out_valid_q;
	erc_pkg::cls_t                    out_cls_q;
	logic [erc_pkg::AVG_W-1:0]        out_avg_q;
	logic [erc_pkg::STAT_W-1:0]       out_bin_q [NUM_BINS];

	logic [erc_pkg::TS_W-1:0]         raw_iv;
	logic [IB-1:0]                    sat_iv;
	logic [CNT_W-1:0]                 count_inc;
	logic [WC_W-1:0]                  cap;
	logic [CNT_W-1:0]                 count_nx;
	logic [OW-1:0]                    old_sum;
	logic [erc_pkg::IDX_W-1:0]        oldest;
	logic [erc_pkg::TS_W-1:0]         elapsed;
	erc_pkg::cls_t                    cls;
	logic                             load_out;

	erc_pkg::avg_req_t                avg_req;
	erc_pkg::avg_rsp_t                avg_rsp;
	logic                             rd_en;
	logic [erc_pkg::IDX_W-1:0]        rd_addr;
	logic [IB-1:0]                    rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_lim_q  <= erc_pkg::LIM_W'(100);
			slow_lim_q  <= erc_pkg::LIM_W'(300);
			pause_lim_q <= erc_pkg::LIM_W'(1000);
			win_len_q   <= erc_pkg::WIN_W'(20);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FAST:  fast_lim_q  <= cfg_data;
				CFG_SLOW:  slow_lim_q  <= cfg_data;
				CFG_PAUSE: pause_lim_q <= cfg_data;
				CFG_WIN:   win_len_q   <= cfg_data[erc_pkg::WIN_W-1:0];
			endcase
		end
	end

	// interval, ring pointers and class
	always_comb begin
		raw_iv    = now_q - last_q;
		sat_iv    = (raw_iv > IV_MAX) ? '1 : raw_iv[IB-1:0];
		count_inc = (count_q < CNT_W'(erc_pkg::HIST_DEPTH)) ? count_q + 1'b1 : count_q;
		cap       = (WC_W'(win_len_q) > WC_W'(erc_pkg::HIST_DEPTH)) ?
			WC_W'(erc_pkg::HIST_DEPTH) : WC_W'(win_len_q);
		count_nx  = (WC_W'(count_inc) > cap) ? cap[CNT_W-1:0] : count_inc;
		old_sum   = OW'(head_q) + OW'(erc_pkg::HIST_DEPTH) - OW'(count_q);
		if (old_sum >= OW'(erc_pkg::HIST_DEPTH)) begin
			old_sum = old_sum - OW'(erc_pkg::HIST_DEPTH);
		end
		oldest    = old_sum[erc_pkg::IDX_W-1:0];
		elapsed   = now_q - last_q;
		if (!seen_q || count_q == '0) begin
			cls = erc_pkg::CLS_NORMAL;
		end else if (elapsed > erc_pkg::TS_W'(pause_lim_q)) begin
			cls = erc_pkg::CLS_PAUSED;
		end else if (avg_q < fast_lim_q) begin
			cls = erc_pkg::CLS_FAST;
		end else if (avg_q < slow_lim_q) begin
			cls = erc_pkg::CLS_NORMAL;
		end else begin
			cls = erc_pkg::CLS_SLOW;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_CLASS) && (!out_valid_q || out_ready);

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= 1'b0;
			last_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
			avg_q   <= '0;
			for (int b = 0; b < NUM_BINS; b++) begin
				bin_q[b] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (req_type == erc_pkg::REQ_EVENT) ? ST_IVAL : ST_CLASS;
					end
				end
				ST_IVAL: begin
					last_q  <= now_q;
					seen_q  <= 1'b1;
					state_q <= seen_q ? ST_BIN : ST_CLASS;
				end
				ST_BIN: begin
					head_q  <= (head_q == erc_pkg::IDX_W'(erc_pkg::HIST_DEPTH - 1)) ?
						'0 : head_q + 1'b1;
					count_q <= count_nx;
					bin_q[BIN_TOTAL] <= sat_inc(bin_q[BIN_TOTAL]);
					if (CMP_W'(iv_q) < CMP_W'(fast_lim_q)) begin
						bin_q[BIN_FAST] <= sat_inc(bin_q[BIN_FAST]);
					end else if (CMP_W'(iv_q) < CMP_W'(slow_lim_q)) begin
						bin_q[BIN_NORMAL] <= sat_inc(bin_q[BIN_NORMAL]);
					end else if (CMP_W'(iv_q) < CMP_W'(pause_lim_q)) begin
						bin_q[BIN_SLOW] <= sat_inc(bin_q[BIN_SLOW]);
					end else begin
						bin_q[BIN_PAUSE] <= sat_inc(bin_q[BIN_PAUSE]);
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (avg_rsp.done) begin
						avg_q   <= avg_rsp.avg;
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and interval holding registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q <= now_ms;
		end
		if (state_q == ST_IVAL) begin
			iv_q <= sat_iv;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cls_q <= cls;
			out_avg_q <= avg_q;
			for (int b = 0; b < NUM_BINS; b++) begin
				out_bin_q[b] <= bin_q[b];
			end
		end
	end

	// interval history ring
	erc_ram #(
		.WIDTH (IB),
		.DEPTH (erc_pkg::HIST_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_BIN),
		.waddr (head_q),
		.wdata (iv_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// weighted average unit
	always_comb begin
		avg_req.start  = (state_q == ST_START);
		avg_req.n      = count_q;
		avg_req.oldest = oldest;
	end

	erc_avg u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.avg_req (avg_req),
		.avg_rsp (avg_rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ports
	assign out_valid       = out_valid_q;
	assign speed_class     = out_cls_q;
	assign avg_interval_ms = out_avg_q;
	assign total_events    = out_bin_q[BIN_TOTAL];
	assign fast_count      = out_bin_q[BIN_FAST];
	assign normal_count    = out_bin_q[BIN_NORMAL];
	assign slow_count      = out_bin_q[BIN_SLOW];
	assign pause_count     = out_bin_q[BIN_PAUSE];

endmodule

`default_nettype wire

// File: rtl/erc_checker.sv
// port level checks of the event rate classifier, bound to the top level
`default_nettype none

module erc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [1:0]                    speed_class,
	input wire logic [erc_pkg::AVG_W-1:0]     avg_interval_ms,
	input wire logic [erc_pkg::STAT_W-1:0]    total_events,
	input wire logic [erc_pkg::STAT_W-1:0]    fast_count,
	input wire logic [erc_pkg::STAT_W-1:0]    normal_count,
	input wire logic [erc_pkg::STAT_W-1:0]    slow_count,
	input wire logic [erc_pkg::STAT_W-1:0]    pause_count
);

	logic                          have_prev_q;
	logic [erc_pkg::STAT_W-1:0]    prev_total_q;
	logic [erc_pkg::STAT_W+2:0]    bin_sum;

	// total seen at the previous delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_total_q <= '0;
		end else if (out_valid && out_ready) begin
			have_prev_q  <= 1'b1;
			prev_total_q <= total_events;
		end
	end

	assign bin_sum = (erc_pkg::STAT_W+3)'(fast_count) + (erc_pkg::STAT_W+3)'(normal_count)
		+ (erc_pkg::STAT_W+3)'(slow_count) + (erc_pkg::STAT_W+3)'(pause_count);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_events)
			&& $stable(speed_class) && $stable(avg_interval_ms))
		else $error("output word changed while stalled");

	// the bins partition the total until it saturates
	a_bins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_events != '1 |->
			bin_sum == (erc_pkg::STAT_W+3)'(total_events))
		else $error("bin counters do not add up to the total");

	// each request adds at most one interval
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && have_prev_q |->
			total_events >= prev_total_q && total_events - prev_total_q <= 1)
		else $error("total count stepped by more than one");

	// with no interval measured the class is normal and the average is zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_events == '0 |->
			speed_class == erc_pkg::CLS_NORMAL && avg_interval_ms == '0)
		else $error("class or average set before any interval");

endmodule

bind event_rate_classifier erc_checker u_erc_checker (.*);

`default_nettype wire

// File: dv/erc_tb_pkg.sv
// register indexes shared by the event rate classifier testbench files
`timescale 1ns / 100ps

package erc_tb_pkg;

	// configuration port register map
	typedef enum logic [1:0] {
		REG_FAST_LIMIT  = 2'd0,
		REG_SLOW_LIMIT  = 2'd1,
		REG_PAUSE_LIMIT = 2'd2,
		REG_WINDOW_LEN  = 2'd3
	} erc_reg_t;

endpackage

// File: dv/erc_checker.sv
// scoreboard of the event rate classifier: predicts each result word and compares it
`timescale 1ns / 100ps

module erc_tb_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [erc_pkg::LIM_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        req_type,
	input  logic [erc_pkg::TS_W-1:0]    now_ms,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  speed_class,
	input  logic [erc_pkg::AVG_W-1:0]   avg_interval_ms,
	input  logic [erc_pkg::STAT_W-1:0]  total_events,
	input  logic [erc_pkg::STAT_W-1:0]  fast_count,
	input  logic [erc_pkg::STAT_W-1:0]  normal_count,
	input  logic [erc_pkg::STAT_W-1:0]  slow_count,
	input  logic [erc_pkg::STAT_W-1:0]  pause_count,
	output int                          fail_count,
	output int                          pending
);
	import erc_pkg::*;
	import erc_tb_pkg::*;

	typedef struct packed {
		cls_t              cls;
		logic [AVG_W-1:0]  avg;
		logic [STAT_W-1:0] total;
		logic [STAT_W-1:0] fast;
		logic [STAT_W-1:0] normal;
		logic [STAT_W-1:0] slow;
		logic [STAT_W-1:0] pause;
	} rate_word_t;

	// predicted classifier state
	logic                     seen_first_q;
	logic [TS_W-1:0]          stamp_q;
	logic [INTERVAL_BITS-1:0] ring_q [HIST_DEPTH];
	int                       head_q;
	int                       count_q;
	logic [STAT_W-1:0]        total_q, fast_q, normal_q, slow_q, pause_q;
	logic [AVG_W-1:0]         avg_q;

	// predicted register contents
	logic [LIM_W-1:0]         fast_lim, slow_lim, pause_lim;
	logic [WIN_W-1:0]         win_len;

	rate_word_t               expected_words[$];
	int                       errs;

	function automatic logic [STAT_W-1:0] sat_inc(logic [STAT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// newer intervals weigh more; integer form of the weights
	function automatic logic [AVG_W-1:0] weighted_average();
		longint unsigned n, acc, quo, iv;
		int k;
		if (count_q == 0)
			return DEFAULT_AVG;
		n = count_q;
		acc = 0;
		for (k = 0; k < count_q; k++) begin
			iv = ring_q[(head_q + HIST_DEPTH - count_q + k) % HIST_DEPTH];
			acc += iv * (n + k) / n;
		end
		quo = 2 * acc / (3 * n - 1);
		return (quo > 64'hFFFF) ? '1 : quo[AVG_W-1:0];
	endfunction

	// interval into the window, bins and average
	function automatic void record_event(logic [TS_W-1:0] ts);
		logic [TS_W-1:0]          raw;
		logic [INTERVAL_BITS-1:0] iv;
		int                       cap;
		if (seen_first_q) begin
			raw = ts - stamp_q;
			iv = (raw[TS_W-1:INTERVAL_BITS] != 0) ? '1 : raw[INTERVAL_BITS-1:0];
			cap = (win_len > HIST_DEPTH) ? HIST_DEPTH : int'(win_len);
			ring_q[head_q] = iv;
			head_q = (head_q + 1) % HIST_DEPTH;
			if (count_q < HIST_DEPTH)
				count_q++;
			if (count_q > cap)
				count_q = cap;
			total_q = sat_inc(total_q);
			if (iv < fast_lim)
				fast_q = sat_inc(fast_q);
			else if (iv < slow_lim)
				normal_q = sat_inc(normal_q);
			else if (iv < pause_lim)
				slow_q = sat_inc(slow_q);
			else
				pause_q = sat_inc(pause_q);
			avg_q = weighted_average();
		end
		stamp_q = ts;
		seen_first_q = 1'b1;
	endfunction

	function automatic cls_t speed_of(logic [TS_W-1:0] elapsed);
		if (!seen_first_q || count_q == 0)
			return CLS_NORMAL;
		if (elapsed > TS_W'(pause_lim))
			return CLS_PAUSED;
		if (avg_q < fast_lim)
			return CLS_FAST;
		if (avg_q < slow_lim)
			return CLS_NORMAL;
		return CLS_SLOW;
	endfunction

	function automatic rate_word_t predict_word(logic rt, logic [TS_W-1:0] ts);
		rate_word_t w;
		if (rt == REQ_EVENT) begin
			record_event(ts);
			w.cls = speed_of('0);
		end else begin
			w.cls = speed_of(ts - stamp_q);
		end
		w.avg    = avg_q;
		w.total  = total_q;
		w.fast   = fast_q;
		w.normal = normal_q;
		w.slow   = slow_q;
		w.pause  = pause_q;
		return w;
	endfunction

	task automatic compare_field(string tag, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
			errs++;
		end
	endtask

	// watch config writes and both channels
	always @(posedge clk or negedge arst_n) begin
		rate_word_t want;
		int         k;
		if (!arst_n) begin
			seen_first_q = 1'b0;
			stamp_q      = '0;
			for (k = 0; k < HIST_DEPTH; k++)
				ring_q[k] = '0;
			head_q    = 0;
			count_q   = 0;
			total_q   = '0;
			fast_q    = '0;
			normal_q  = '0;
			slow_q    = '0;
			pause_q   = '0;
			avg_q     = '0;
			fast_lim  = LIM_W'(100);
			slow_lim  = LIM_W'(300);
			pause_lim = LIM_W'(1000);
			win_len   = WIN_W'(20);
			expected_words.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FAST_LIMIT:  fast_lim  = cfg_data;
					REG_SLOW_LIMIT:  slow_lim  = cfg_data;
					REG_PAUSE_LIMIT: pause_lim = cfg_data;
					REG_WINDOW_LEN:  win_len   = cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			// result word against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected, got class %0d avg %0d total %0d",
						$time, speed_class, avg_interval_ms, total_events);
					errs++;
				end else begin
					want = expected_words[0];
					expected_words.delete(0);
					compare_field("speed_class", want.cls, speed_class);
					compare_field("avg_interval_ms", want.avg, avg_interval_ms);
					compare_field("total_events", want.total, total_events);
					compare_field("fast_count", want.fast, fast_count);
					compare_field("normal_count", want.normal, normal_count);
					compare_field("slow_count", want.slow, slow_count);
					compare_field("pause_count", want.pause, pause_count);
				end
			end
			// request word accepted: predict its result
			if (in_valid && in_ready)
				expected_words.insert(expected_words.size(), predict_word(req_type, now_ms));
			fail_count <= errs;
			pending    <= expected_words.size();
		end
	end

endmodule

// File: dv/tb_event_rate_classifier.sv
// testbench top of the event rate classifier: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_event_rate_classifier;
	import erc_pkg::*;
	import erc_tb_pkg::*;

	localparam int RUN_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [1:0]           cfg_index;
	logic [LIM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic [TS_W-1:0]      now_ms;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           speed_class;
	logic [AVG_W-1:0]     avg_interval_ms;
	logic [STAT_W-1:0]    total_events;
	logic [STAT_W-1:0]    fast_count;
	logic [STAT_W-1:0]    normal_count;
	logic [STAT_W-1:0]    slow_count;
	logic [STAT_W-1:0]    pause_count;
	int                   fail_count;
	int                   pending;

	// stimulus state
	logic                 calm;
	logic [TS_W-1:0]      clock_ms;
	int                   lim_fast, lim_slow, lim_pause;
	int                   n_events, n_queries, n_settings;

	event_rate_classifier i_dut (.*);

	erc_tb_checker i_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_event_rate_classifier: FAIL");
		$finish;
	end

	// result side stalls in bursts
	initial begin : result_sink
		out_ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// one request word, held until accepted; valid stays up for a follow-on word
	task automatic issue(logic rt, logic [TS_W-1:0] ts);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		now_ms   <= ts;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (rt == REQ_EVENT)
			n_events++;
		else
			n_queries++;
	endtask

	task automatic event_after(logic [TS_W-1:0] gap);
		clock_ms = clock_ms + gap;
		issue(REQ_EVENT, clock_ms);
	endtask

	task automatic query_at(logic [TS_W-1:0] ts);
		issue(REQ_QUERY, ts);
	endtask

	// wait until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// write all four registers back to back while idle
	task automatic apply_settings(logic [LIM_W-1:0] f, logic [LIM_W-1:0] s,
			logic [LIM_W-1:0] p, logic [LIM_W-1:0] wdata);
		cfg_write <= 1'b1;
		cfg_index <= REG_FAST_LIMIT;
		cfg_data  <= f;
		@(posedge clk);
		cfg_index <= REG_SLOW_LIMIT;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= REG_PAUSE_LIMIT;
		cfg_data  <= p;
		@(posedge clk);
		cfg_index <= REG_WINDOW_LEN;
		cfg_data  <= wdata;
		@(posedge clk);
		cfg_write <= 1'b0;
		lim_fast  = int'(f);
		lim_slow  = int'(s);
		lim_pause = int'(p);
		n_settings++;
	endtask

	// interval between events, partly clustered around the bin limits
	function automatic logic [TS_W-1:0] pick_gap();
		int lim, v;
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return $urandom_range(0, 2 * lim_fast + 1);
			3, 4, 5: begin
				case ($urandom_range(0, 2))
					0: lim = lim_fast;
					1: lim = lim_slow;
					default: lim = lim_pause;
				endcase
				v = lim + int'($urandom_range(0, 4)) - 2;
				return (v < 0) ? '0 : TS_W'(v);
			end
			6, 7: return $urandom_range(0, 3000);
			8: return $urandom_range(60000, 70000);
			default: return $urandom();
		endcase
	endfunction

	// time since the last event for a status query
	function automatic logic [TS_W-1:0] pick_elapsed();
		int v;
		case ($urandom_range(0, 3))
			0: begin
				v = lim_pause + int'($urandom_range(0, 4)) - 2;
				return (v < 0) ? '0 : TS_W'(v);
			end
			1: return $urandom_range(0, 2 * lim_pause + 2);
			2: return $urandom();
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return LIM_W'($urandom_range(0, 1500));
		endcase
	endfunction

	task automatic random_phase(int words);
		int k;
		for (k = 0; k < words; k++) begin
			if ($urandom_range(0, 9) < 7)
				event_after(pick_gap());
			else
				query_at(clock_ms + pick_elapsed());
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [LIM_W-1:0] wdata;
		int               p;
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = REG_FAST_LIMIT;
		cfg_data   = '0;
		in_valid   = 1'b0;
		req_type   = REQ_EVENT;
		now_ms     = '0;
		calm       = 1'b0;
		clock_ms   = '0;
		lim_fast   = 100;
		lim_slow   = 300;
		lim_pause  = 1000;
		n_events   = 0;
		n_queries  = 0;
		n_settings = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset settings
		query_at(32'h0000_1234);        // nothing seen yet
		clock_ms = 32'hFFFF_FF00;
		issue(REQ_EVENT, clock_ms);      // first event only takes the stamp
		query_at(clock_ms + 5);          // no history yet
		event_after(32'h0000_0200);      // interval across the stamp wrap
		event_after(0);
		event_after(99);
		event_after(100);
		event_after(299);
		event_after(300);
		event_after(999);
		event_after(1000);
		event_after(70000);              // interval saturates
		query_at(clock_ms + 1000);       // elapsed equal to the pause limit
		query_at(clock_ms + 1001);       // just past it
		query_at(clock_ms - 1);          // elapsed wraps to a huge value
		query_at(32'hFFFF_FFFF);
		query_at(32'h0000_0000);
		event_after(32'hFFFF_FFFF);      // backwards stamp, huge interval
		event_after(10);
		event_after(12);
		event_after(8);
		query_at(clock_ms + 3);
		drain();

		// extreme and hand-picked settings
		apply_settings('0, '0, '0, '0);              // empty window
		random_phase(40);
		drain();
		apply_settings('1, '1, '1, LIM_W'(32));     // all limits at the top, full window
		random_phase(100);
		drain();
		// window masks to 63, clamps to depth
		apply_settings(LIM_W'(150), LIM_W'(400), LIM_W'(1200), '1);
		random_phase(80);
		drain();
		// window shrinks from full
		apply_settings(LIM_W'(50), LIM_W'(200), LIM_W'(800), LIM_W'(3));
		random_phase(60);
		drain();
		// limits out of order
		apply_settings(LIM_W'(300), LIM_W'(100), LIM_W'(600), LIM_W'(1));
		random_phase(60);
		drain();
		apply_settings(LIM_W'(100), LIM_W'(300), LIM_W'(1000), LIM_W'(20));
		random_phase(80);
		drain();

		// random settings; all but the first put random upper data bits on the window write
		for (p = 0; p < 5; p++) begin
			wdata = {(LIM_W-WIN_W)'($urandom_range(0, 1023)), WIN_W'($urandom_range(0, 40))};
			if (p == 0)
				wdata = LIM_W'(32);
			apply_settings(pick_limit(), pick_limit(), pick_limit(), wdata);
			random_phase(60);
			drain();
		end

		// closing stretch without idling
		apply_settings(LIM_W'(90), LIM_W'(250), LIM_W'(900), LIM_W'(32));
		calm = 1'b1;
		random_phase(100);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d events and %0d status queries over %0d register settings,",
			n_events, n_queries, n_settings);
		$display("including an empty window, clamped and shrunk windows and stamp wrap");
		if (fail_count == 0)
			$display("tb_event_rate_classifier: PASS");
		else
			$display("tb_event_rate_classifier: FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/erc_pkg.sv
rtl/erc_ram.sv
rtl/erc_div.sv
rtl/erc_avg.sv
rtl/event_rate_classifier.sv
rtl/erc_checker.sv
dv/erc_tb_pkg.sv
dv/erc_checker.sv
dv/tb_event_rate_classifier.sv
